// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define JSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is low
`define JSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// types, constants and helper functions of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int CP_W     = 21;
    localparam int MAX_RES  = 4;
    localparam int CNT_W    = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // upper six bits of a surrogate code unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_U      = 8'h75;

    localparam logic [BYTE_W-1:0] BS_CODE  = 8'h08;
    localparam logic [BYTE_W-1:0] FF_CODE  = 8'h0C;
    localparam logic [BYTE_W-1:0] LF_CODE  = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_CODE  = 8'h0D;
    localparam logic [BYTE_W-1:0] TAB_CODE = 8'h09;

    // register byte offset of the null-enable flag
    localparam logic [APB_AW-1:0] REG_NUL_EN = 3'd0;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_BS2    = 3'd3,
        MODE_U2     = 3'd4,
        MODE_HEX2   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ESCAPE  = 2'd1,
        ERR_NULL    = 2'd2,
        ERR_UNICODE = 2'd3
    } t_err;

    typedef struct packed {
        t_mode             mode;
        logic [1:0]        hex_cnt;
        logic [UNIT_W-1:0] high;
        logic [UNIT_W-1:0] low;
    } t_dec_state;

    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               n;
        t_kind                          kind;
        t_err                           code;
    } t_dec_res;

    typedef struct packed {
        logic             ready_in;
        logic [CNT_W-1:0] cnt;
    } t_ob_status;

    localparam t_dec_state ST_CLEAR = '{
        mode: MODE_NORMAL, hex_cnt: 2'd0, high: 16'h0000, low: 16'h0000};

    localparam t_dec_res RES_NONE = '{
        bytes: '0, n: 3'd0, kind: KIND_DATA, code: ERR_NONE};

    // {bad, value}: bad is set for a byte that is no hex digit
    function automatic logic [4:0] f_hex(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else begin
            r = 5'h10;
        end
        return r;
    endfunction

    function automatic t_dec_res f_word(input logic [BYTE_W-1:0] b, input t_kind k,
                                        input t_err e);
        t_dec_res r;
        r          = RES_NONE;
        r.bytes[0] = b;
        r.n        = 3'd1;
        r.kind     = k;
        r.code     = e;
        return r;
    endfunction

    // utf-8 encoding of a nonzero code point, lead byte in slot 0
    function automatic t_dec_res f_utf8(input logic [CP_W-1:0] cp);
        t_dec_res r;
        r = RES_NONE;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.n        = 3'd1;
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.n        = 3'd2;
        end else if (cp < SUPP_BASE) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.n        = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.n        = 3'd4;
        end
        return r;
    endfunction

endpackage

// File: src/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// valid/ready stream channels of the json string unescaper
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last, output ready);
endinterface

// File: src/jsu_cfg.sv
// ----------------------------------------------------------------------------
// jsu_cfg
// apb register file holding the null-enable flag
// ----------------------------------------------------------------------------
module jsu_cfg
    import jsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic              o_nul_en
);

    logic r_nul_en;
    logic wr_en;

    // register index is paddr / 4, only index zero exists
    assign wr_en = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_NUL_EN[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nul_en <= 1'b0;
        end else if (wr_en) begin
            r_nul_en <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_NUL_EN[APB_AW-1:2]) begin
            prdata[0] = r_nul_en;
        end
    end

    assign pready   = 1'b1;
    assign o_nul_en = r_nul_en;

endmodule

// File: src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// escape decoder: mode state register and per-byte result logic
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_nul_en,
    output t_dec_res          o_res,
    output t_mode             o_mode
);

    t_dec_state        r_state;
    t_dec_state        n_state;
    t_dec_res          res;
    logic [4:0]        hexd;
    logic [UNIT_W-1:0] unit_hi;
    logic [UNIT_W-1:0] unit_lo;
    logic [CP_W-1:0]   cp;
    logic              do_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign hexd    = f_hex(i_byte);
    assign unit_hi = {r_state.high[UNIT_W-5:0], hexd[3:0]};
    assign unit_lo = {r_state.low[UNIT_W-5:0], hexd[3:0]};

    always_comb begin
        n_state = r_state;
        res     = RES_NONE;
        cp      = '0;
        do_cp   = 1'b0;
        unique case (r_state.mode)
            MODE_ESC: begin
                n_state = ST_CLEAR;
                unique case (i_byte)
                    CH_QUOTE, CH_SLASH, CH_BSLASH: res = f_word(i_byte, KIND_DATA, ERR_NONE);
                    CH_B: res = f_word(BS_CODE, KIND_DATA, ERR_NONE);
                    CH_F: res = f_word(FF_CODE, KIND_DATA, ERR_NONE);
                    CH_N: res = f_word(LF_CODE, KIND_DATA, ERR_NONE);
                    CH_R: res = f_word(CR_CODE, KIND_DATA, ERR_NONE);
                    CH_T: res = f_word(TAB_CODE, KIND_DATA, ERR_NONE);
                    CH_ZERO: begin
                        if (i_nul_en) begin
                            res = f_word(8'h00, KIND_DATA, ERR_NONE);
                        end else begin
                            res = f_word(8'h00, KIND_ERR, ERR_NULL);
                        end
                    end
                    CH_U: n_state.mode = MODE_HEX1;
                    default: res = f_word(8'h00, KIND_ERR, ERR_ESCAPE);
                endcase
            end
            MODE_HEX1: begin
                if (hexd[4]) begin
                    n_state = ST_CLEAR;
                    res     = f_word(8'h00, KIND_ERR, ERR_UNICODE);
                end else begin
                    n_state.high = unit_hi;
                    if (r_state.hex_cnt != 2'd3) begin
                        n_state.hex_cnt = r_state.hex_cnt + 2'd1;
                    end else begin
                        n_state.hex_cnt = 2'd0;
                        if (unit_hi[15:10] == SURR_LOW_TAG) begin
                            n_state = ST_CLEAR;
                            res     = f_word(8'h00, KIND_ERR, ERR_UNICODE);
                        end else if (unit_hi[15:10] == SURR_HIGH_TAG) begin
                            n_state.mode = MODE_BS2;
                        end else begin
                            do_cp = 1'b1;
                            cp    = {5'd0, unit_hi};
                        end
                    end
                end
            end
            MODE_BS2: begin
                if (i_byte != CH_BSLASH) begin
                    n_state = ST_CLEAR;
                    res     = f_word(8'h00, KIND_ERR, ERR_UNICODE);
                end else begin
                    n_state.mode = MODE_U2;
                end
            end
            MODE_U2: begin
                if (i_byte != CH_U) begin
                    n_state = ST_CLEAR;
                    res     = f_word(8'h00, KIND_ERR, ERR_UNICODE);
                end else begin
                    n_state.mode    = MODE_HEX2;
                    n_state.hex_cnt = 2'd0;
                    n_state.low     = '0;
                end
            end
            MODE_HEX2: begin
                if (hexd[4]) begin
                    n_state = ST_CLEAR;
                    res     = f_word(8'h00, KIND_ERR, ERR_UNICODE);
                end else begin
                    n_state.low = unit_lo;
                    if (r_state.hex_cnt != 2'd3) begin
                        n_state.hex_cnt = r_state.hex_cnt + 2'd1;
                    end else if (unit_lo[15:10] != SURR_LOW_TAG) begin
                        n_state = ST_CLEAR;
                        res     = f_word(8'h00, KIND_ERR, ERR_UNICODE);
                    end else begin
                        do_cp = 1'b1;
                        cp    = SUPP_BASE + {1'b0, r_state.high[9:0], unit_lo[9:0]};
                    end
                end
            end
            default: begin
                // normal body, stray codes included
                n_state = ST_CLEAR;
                if (i_byte == CH_BSLASH) begin
                    n_state.mode = MODE_ESC;
                end else if (i_byte == CH_QUOTE) begin
                    res = f_word(8'h00, KIND_END, ERR_NONE);
                end else if (i_byte == 8'h00 && !i_nul_en) begin
                    res = f_word(8'h00, KIND_ERR, ERR_NULL);
                end else begin
                    res = f_word(i_byte, KIND_DATA, ERR_NONE);
                end
            end
        endcase

        if (do_cp) begin
            n_state = ST_CLEAR;
            if (cp == '0) begin
                if (i_nul_en) begin
                    res = f_word(8'h00, KIND_DATA, ERR_NONE);
                end else begin
                    res = f_word(8'h00, KIND_ERR, ERR_NULL);
                end
            end else begin
                res = f_utf8(cp);
            end
        end
    end

    assign o_res  = res;
    assign o_mode = r_state.mode;

endmodule

// File: src/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf
// result register that drains up to four words, one per cycle while the sink is ready
// ----------------------------------------------------------------------------
module jsu_outbuf
    import jsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_dec_res         i_res,
    jsu_out_if.source        o_out,
    output t_ob_status       o_status
);

    logic [MAX_RES-1:0][BYTE_W-1:0] r_bytes;
    t_kind                          r_kind;
    t_err                           r_code;
    logic [CNT_W-1:0]               r_cnt;
    logic                           take;

    assign take = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_res.n;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_kind  <= i_res.kind;
            r_code  <= i_res.code;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[MAX_RES-1:1]};
        end
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_byte   = r_bytes[0];
    assign o_out.kind       = r_kind;
    assign o_out.error_code = r_code;
    assign o_out.last       = (r_cnt == 3'd1);

    // free when empty or when the final word leaves this cycle
    assign o_status.ready_in = (r_cnt == '0) || ((r_cnt == 3'd1) && o_out.ready);
    assign o_status.cnt      = r_cnt;

endmodule

// File: src/json_string_unescape.sv
// an accepted byte has its result words loaded into the result register by the accepting edge
// throughput: one input byte per cycle when each byte yields at most one word and the sink is
// ready; a \u escape that ends in an n-byte utf-8 sequence holds input ready low until the
// last word is leaving the single result register, draining one word per cycle if the sink is ready
// reset: synchronous, active low; clears decode mode, result count and the null-enable flag
// ----------------------------------------------------------------------------
// json_string_unescape
// json string body unescaper with utf-8 output of \u escapes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_unescape
    import jsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    jsu_in_if.sink            i_in,
    jsu_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic       nul_en;
    logic       in_accept;
    t_dec_res   dec_res;
    t_mode      dec_mode;
    t_ob_status ob_status;

    // configuration register, to be written only while the stream is idle; the block does not enforce this
    jsu_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_nul_en (nul_en)
    );

    // a word is taken whenever the result register is free after this edge
    assign i_in.ready = ob_status.ready_in;
    assign in_accept  = i_in.valid && i_in.ready;

    // decoder: state advances only on an accepted word, results computed in the same cycle
    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.in_byte),
        .i_nul_en (nul_en),
        .o_res    (dec_res),
        .o_mode   (dec_mode)
    );

    // result register, loaded with all words of one input byte at once
    jsu_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_res    (dec_res),
        .o_out    (o_out),
        .o_status (ob_status)
    );

    // no new word while more than one result word is still waiting
    `JSU_ASSERT_IMP(a_busy_blocks_input, i_clk, i_rst_n, ob_status.cnt > 3'd1, !i_in.ready)
    // end and error results are always single words
    `JSU_ASSERT_IMP(a_nondata_is_last, i_clk, i_rst_n, o_out.valid && (o_out.kind != KIND_DATA), o_out.last)
    // an error drops the decoder back to normal body mode
    `JSU_ASSERT_NXT(a_err_clears_mode, i_clk, i_rst_n, in_accept && (dec_res.kind == KIND_ERR), dec_mode == MODE_NORMAL)
    // a word with no result leaves the result register empty
    `JSU_ASSERT_NXT(a_silent_word_empty, i_clk, i_rst_n, in_accept && (dec_res.n == 3'd0), ob_status.cnt == 3'd0)

endmodule

// File: tb/sv/unescape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unescape_checker
// watches the byte and word channels and the register port of the json
// string unescaper, predicts every result word and compares it field by field
// ----------------------------------------------------------------------------
module unescape_checker
    import jsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    jsu_in_if                 i_in,
    jsu_out_if                i_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_words_checked
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_kind             kind;
        t_err              code;
        logic              last;
    } t_word;

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
    localparam int                MAX_PRINTS = 30;

    t_word             expected_words[$];
    t_mode             dec_mode    = MODE_NORMAL;
    logic [1:0]        digit_cnt   = 2'd0;
    logic [UNIT_W-1:0] first_unit  = '0;
    logic [UNIT_W-1:0] second_unit = '0;
    logic              null_ok     = 1'b0;
    int                fail_total  = 0;
    int                words_total = 0;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_total++;
        if (fail_total <= MAX_PRINTS) begin
            $display("%0t ns: mismatch in %s, got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // {bad, value}
    function automatic logic [4:0] digit_of(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    task automatic clear_decoder();
        dec_mode    = MODE_NORMAL;
        digit_cnt   = 2'd0;
        first_unit  = '0;
        second_unit = '0;
    endtask

    task automatic add_word(input logic [BYTE_W-1:0] b, input t_kind k, input t_err e);
        t_word w;
        w.data = b;
        w.kind = k;
        w.code = e;
        w.last = 1'b0;
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic fail_with(input t_err e);
        clear_decoder();
        add_word(8'h00, KIND_ERR, e);
    endtask

    task automatic emit_point(input logic [CP_W-1:0] cp);
        if (cp == '0) begin
            if (!null_ok) begin
                fail_with(ERR_NULL);
                return;
            end
        end
        clear_decoder();
        if (cp < 21'h80) begin
            add_word(cp[7:0], KIND_DATA, ERR_NONE);
        end else if (cp < 21'h800) begin
            add_word(8'hC0 | 8'(cp[10:6]), KIND_DATA, ERR_NONE);
            add_word(8'h80 | 8'(cp[5:0]), KIND_DATA, ERR_NONE);
        end else if (cp < SUPP_BASE) begin
            add_word(8'hE0 | 8'(cp[15:12]), KIND_DATA, ERR_NONE);
            add_word(8'h80 | 8'(cp[11:6]), KIND_DATA, ERR_NONE);
            add_word(8'h80 | 8'(cp[5:0]), KIND_DATA, ERR_NONE);
        end else begin
            add_word(8'hF0 | 8'(cp[20:18]), KIND_DATA, ERR_NONE);
            add_word(8'h80 | 8'(cp[17:12]), KIND_DATA, ERR_NONE);
            add_word(8'h80 | 8'(cp[11:6]), KIND_DATA, ERR_NONE);
            add_word(8'h80 | 8'(cp[5:0]), KIND_DATA, ERR_NONE);
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] c);
        int                size_before;
        logic [4:0]        d;
        logic [UNIT_W-1:0] hi_off;
        logic [UNIT_W-1:0] lo_off;
        t_word             w;
        size_before = expected_words.size();
        d = digit_of(c);
        case (dec_mode)
            MODE_ESC: begin
                case (c)
                    CH_QUOTE, CH_SLASH, CH_BSLASH: begin
                        clear_decoder();
                        add_word(c, KIND_DATA, ERR_NONE);
                    end
                    CH_B: begin
                        clear_decoder();
                        add_word(BS_CODE, KIND_DATA, ERR_NONE);
                    end
                    CH_F: begin
                        clear_decoder();
                        add_word(FF_CODE, KIND_DATA, ERR_NONE);
                    end
                    CH_N: begin
                        clear_decoder();
                        add_word(LF_CODE, KIND_DATA, ERR_NONE);
                    end
                    CH_R: begin
                        clear_decoder();
                        add_word(CR_CODE, KIND_DATA, ERR_NONE);
                    end
                    CH_T: begin
                        clear_decoder();
                        add_word(TAB_CODE, KIND_DATA, ERR_NONE);
                    end
                    CH_ZERO: begin
                        if (!null_ok) begin
                            fail_with(ERR_NULL);
                        end else begin
                            clear_decoder();
                            add_word(8'h00, KIND_DATA, ERR_NONE);
                        end
                    end
                    CH_U: begin
                        dec_mode   = MODE_HEX1;
                        digit_cnt  = 2'd0;
                        first_unit = '0;
                    end
                    default: fail_with(ERR_ESCAPE);
                endcase
            end
            MODE_HEX1: begin
                if (d[4]) begin
                    fail_with(ERR_UNICODE);
                end else begin
                    first_unit = {first_unit[11:0], d[3:0]};
                    if (digit_cnt != 2'd3) begin
                        digit_cnt++;
                    end else begin
                        digit_cnt = 2'd0;
                        if (first_unit >= LOW_FIRST && first_unit <= LOW_LAST) begin
                            fail_with(ERR_UNICODE);
                        end else if (first_unit >= HIGH_FIRST && first_unit < LOW_FIRST) begin
                            dec_mode = MODE_BS2;
                        end else begin
                            emit_point(CP_W'(first_unit));
                        end
                    end
                end
            end
            MODE_BS2: begin
                if (c != CH_BSLASH) fail_with(ERR_UNICODE);
                else dec_mode = MODE_U2;
            end
            MODE_U2: begin
                if (c != CH_U) begin
                    fail_with(ERR_UNICODE);
                end else begin
                    dec_mode    = MODE_HEX2;
                    digit_cnt   = 2'd0;
                    second_unit = '0;
                end
            end
            MODE_HEX2: begin
                if (d[4]) begin
                    fail_with(ERR_UNICODE);
                end else begin
                    second_unit = {second_unit[11:0], d[3:0]};
                    if (digit_cnt != 2'd3) begin
                        digit_cnt++;
                    end else if (second_unit < LOW_FIRST || second_unit > LOW_LAST) begin
                        fail_with(ERR_UNICODE);
                    end else begin
                        // ten bits from each unit on top of the supplementary base
                        hi_off = first_unit - HIGH_FIRST;
                        lo_off = second_unit - LOW_FIRST;
                        emit_point(SUPP_BASE + {1'b0, hi_off[9:0], lo_off[9:0]});
                    end
                end
            end
            default: begin
                if (c == CH_BSLASH) begin
                    clear_decoder();
                    dec_mode = MODE_ESC;
                end else if (c == CH_QUOTE) begin
                    clear_decoder();
                    add_word(8'h00, KIND_END, ERR_NONE);
                end else if (c == 8'h00 && !null_ok) begin
                    fail_with(ERR_NULL);
                end else begin
                    clear_decoder();
                    add_word(c, KIND_DATA, ERR_NONE);
                end
            end
        endcase
        // flag the final word of this byte
        if (expected_words.size() > size_before) begin
            w      = expected_words[expected_words.size() - 1];
            w.last = 1'b1;
            expected_words[expected_words.size() - 1] = w;
        end
    endtask

    task automatic check_word();
        t_word w;
        words_total++;
        if (expected_words.size() == 0) begin
            report_mismatch("word with nothing pending", i_out.out_byte, 0);
            return;
        end
        w = expected_words.pop_front();
        if (i_out.out_byte !== w.data) report_mismatch("out_byte", i_out.out_byte, w.data);
        if (i_out.kind !== w.kind) report_mismatch("kind", i_out.kind, w.kind);
        if (i_out.error_code !== w.code) report_mismatch("error_code", i_out.error_code, w.code);
        if (i_out.last !== w.last) report_mismatch("last", i_out.last, w.last);
    endtask

    // words leave before new bytes are decoded, so a stray word is caught
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            null_ok = 1'b0;
            expected_words.delete();
        end else begin
            if (i_out.valid && i_out.ready) check_word();
            if (psel && penable && pwrite && pready &&
                paddr[APB_AW-1:2] == REG_NUL_EN[APB_AW-1:2]) begin
                null_ok = pwdata[0];
            end
            if (i_in.valid && i_in.ready) decode_byte(i_in.in_byte);
        end
        o_fail_count    <= fail_total;
        o_pending       <= expected_words.size();
        o_words_checked <= words_total;
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives json string bodies into the unescaper through bursts and gaps,
// stalls the word channel on shifting patterns, switches the null flag between
// phases and leaves all checking to the checker beside the block
// ----------------------------------------------------------------------------
module testbench;
    import jsu_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_BYTES  = 120;
    localparam int PHASES        = 4;
    localparam int SETTLE_CYCLES = 6;

    // escape letters that map to a single byte
    localparam logic [BYTE_W-1:0] ESC_LETTERS [8] = '{
        CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // sender and receiver drive these, the channels follow
    logic              tx_valid = 1'b0;
    logic [BYTE_W-1:0] tx_byte  = '0;
    logic              rx_ready = 1'b0;

    int                fail_count;
    int                pending;
    int                words_checked;
    int                bytes_sent    = 0;
    int                burst_left    = 0;
    int                settings_used = 1;
    bit                gaps_on       = 1'b0;
    logic [15:0]       stall_pat     = 16'hFFFF;
    int                stall_age     = 0;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    assign in_ch.valid   = tx_valid;
    assign in_ch.in_byte = tx_byte;
    assign out_ch.ready  = rx_ready;

    json_string_unescape u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    unescape_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: each pattern rotates for a while, then a new one is drawn
    always @(negedge i_clk) begin
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 16'hFFFF;                     // no stalls at all
                1: stall_pat = 16'($urandom) | 16'h0001;     // heavy stalls
                2: stall_pat = 16'($urandom) | 16'($urandom) | 16'h0001;
                default: stall_pat = 16'h5555;               // ready and stall alternate
            endcase
            stall_age = $urandom_range(16, 96);
        end
        rx_ready  <= stall_pat[0];
        stall_pat  = {stall_pat[0], stall_pat[15:1]};
        stall_age--;
    end

    // one byte over the input channel; a gap of random length opens each burst
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && burst_left == 0) begin
            @(negedge i_clk);
            tx_valid <= 1'b0;
            tx_byte  <= BYTE_W'($urandom);   // junk while idle, must be ignored
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        @(negedge i_clk);
        tx_valid <= 1'b1;
        tx_byte  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // hex digit with random letter case
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    task automatic send_unit(input logic [UNIT_W-1:0] u);
        for (int k = 3; k >= 0; k--) send_byte(hex_char(u[4*k +: 4]));
    endtask

    // some good hex digits, then one byte that is no hex digit
    task automatic send_bad_group(input int good);
        logic [BYTE_W-1:0] b;
        repeat (good) send_byte(hex_char(4'($urandom)));
        do begin
            b = BYTE_W'($urandom);
        end while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                   (b >= 8'h41 && b <= 8'h46));
        send_byte(b);
    endtask

    task automatic write_nul_en(input logic v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NUL_EN;
        pwdata  <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, wait for every predicted word, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        tx_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one piece of a string body: mostly well formed, some broken on purpose
    task automatic send_token();
        int                pick;
        logic [BYTE_W-1:0] b;
        logic [UNIT_W-1:0] u;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
        if (pick < 28) begin
            // plain run; quote and backslash only now and then
            repeat ($urandom_range(1, 4)) begin
                b = BYTE_W'($urandom);
                if ((b == CH_BSLASH || b == CH_QUOTE) && $urandom_range(0, 3) != 0) begin
                    b = b ^ 8'h01;
                end
                send_byte(b);
            end
        end else if (pick < 34) begin
            send_byte(8'h00);                                 // raw nul
        end else if (pick < 48) begin
            send_byte(CH_BSLASH);
            send_byte(ESC_LETTERS[$urandom_range(0, 7)]);
        end else if (pick < 52) begin
            send_byte(CH_BSLASH);                             // escaped zero
            send_byte(CH_ZERO);
        end else if (pick < 56) begin
            // unknown escape letter
            do begin
                b = BYTE_W'($urandom);
            end while (b inside {CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_N, CH_R,
                                 CH_T, CH_ZERO, CH_U});
            send_byte(CH_BSLASH);
            send_byte(b);
        end else if (pick < 93) begin
            send_byte(CH_BSLASH);
            send_byte(CH_U);
            case ($urandom_range(0, 9))
                0: send_unit(UNIT_W'($urandom_range('h1, 'h7F)));
                1: send_unit(UNIT_W'($urandom_range('h80, 'h7FF)));
                2: send_unit(UNIT_W'($urandom_range('h800, 'hD7FF)));
                3: send_unit(UNIT_W'($urandom_range('hE000, 'hFFFF)));
                4: send_unit(16'h0000);                       // code point zero
                5: begin
                    send_unit(UNIT_W'($urandom_range('hD800, 'hDBFF)));
                    send_byte(CH_BSLASH);
                    send_byte(CH_U);
                    send_unit(UNIT_W'($urandom_range('hDC00, 'hDFFF)));
                end
                6: begin
                    // pair at the edges of both surrogate ranges
                    send_unit($urandom_range(0, 1) ? 16'hD800 : 16'hDBFF);
                    send_byte(CH_BSLASH);
                    send_byte(CH_U);
                    send_unit($urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF);
                end
                7: send_unit(UNIT_W'($urandom_range('hDC00, 'hDFFF)));   // lone low
                8: send_bad_group($urandom_range(0, 3));
                default: begin
                    // high surrogate, then the second escape goes wrong
                    send_unit(UNIT_W'($urandom_range('hD800, 'hDBFF)));
                    case ($urandom_range(0, 3))
                        0: begin
                            do b = BYTE_W'($urandom); while (b == CH_BSLASH);
                            send_byte(b);
                        end
                        1: begin
                            do b = BYTE_W'($urandom); while (b == CH_U);
                            send_byte(CH_BSLASH);
                            send_byte(b);
                        end
                        2: begin
                            do u = UNIT_W'($urandom); while (u >= 16'hDC00 && u <= 16'hDFFF);
                            send_byte(CH_BSLASH);
                            send_byte(CH_U);
                            send_unit(u);
                        end
                        default: begin
                            send_byte(CH_BSLASH);
                            send_byte(CH_U);
                            send_bad_group($urandom_range(0, 3));
                        end
                    endcase
                end
            endcase
        end else begin
            send_byte(CH_QUOTE);                              // string ends
        end
    endtask

    initial begin
        int target;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, nul refused in both forms, unknown escape,
        // a two byte and a four byte code point, then the closing quote
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("\\0\\q\\u00e9\\uD83D\\uDE00\"");
        settle();

        // random phases alternate the null flag between its two values
        for (int ph = 0; ph < PHASES; ph++) begin
            write_nul_en(ph % 2 == 0);
            settings_used++;
            target = bytes_sent + RANDOM_BYTES / PHASES;
            while (bytes_sent < target) send_token();
            settle();
        end

        $display("run: %0d body bytes under %0d null-flag settings, %0d result words compared",
                 bytes_sent, settings_used, words_checked);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d result words still outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/jsu_pkg.sv
src/jsu_if.sv
src/jsu_cfg.sv
src/jsu_decode.sv
src/jsu_outbuf.sv
src/json_string_unescape.sv
tb/sv/unescape_checker.sv
tb/sv/testbench.sv
